[hw/rtl/psb_pkg.sv]
// ----------------------------------------------------------------------------
// psb_pkg: shared definitions for the prime sieve bitmap unit
// Holds the field widths, command and status codes, and the sequencer states.
// ----------------------------------------------------------------------------
package psb_pkg;

    localparam int unsigned MAP_DEPTH_DEFAULT = 65536;

    localparam int unsigned SIZE_W   = 17;
    localparam int unsigned NUMBER_W = 16;
    localparam int unsigned STATUS_W = 2;

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(65536);

    typedef enum logic {
        CMD_BUILD = 1'b0,
        CMD_QUERY = 1'b1
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK        = 2'd0,
        STATUS_RANGE     = 2'd1,
        STATUS_NOT_BUILT = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DRAIN,
        ST_FILL,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_CLEAR
    } state_t;

endpackage

[hw/rtl/prime_sieve_bitmap_unit.sv]
// ----------------------------------------------------------------------------
// prime_sieve_bitmap_unit: one-bit primality map with a sieve builder
// Builds the map with the Sieve of Eratosthenes in a single-port memory and
// answers primality queries from it.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Signals                       Contents
//  --------  ---------  ----------------------------  ------------------------
//  s_axis    in         tvalid/tready/tdata/tuser     command, query_number
//  m_axis    out        tvalid/tready/tdata/tuser     is_prime, status
//  cfg       in         cfg_we/cfg_wdata              sieve_size
//
//  Each query makes one read of the map memory; back-to-back queries stream
//  at one transfer per cycle while m_axis_tready holds high, and each result
//  passes through the query stage and the output register. A build is one
//  pass of the memory port: a fill of max(n,2) entries, a read and a check
//  of each scanned index below n, and one write for each multiple that is
//  cleared (about n*ln(ln(n)) in total), where n is the effective size.
//  The single memory port paces the build; s_axis_tready is low for the
//  whole build. Reset clears the control state and the built flag and loads
//  the reset size; the map itself needs no clearing pass, since queries are
//  refused until a build is done. A stalled result sits in the output
//  register while the next query is read into the query stage.
//
module prime_sieve_bitmap_unit #(
    parameter int unsigned MAP_DEPTH = psb_pkg::MAP_DEPTH_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,

    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [psb_pkg::NUMBER_W-1:0] s_axis_tdata,  // [15:0] query_number
    input  logic [0:0]                  s_axis_tuser,   // [0] command

    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [7:0]                  m_axis_tdata,   // [0] is_prime, [7:1] zero
    output logic [psb_pkg::STATUS_W-1:0] m_axis_tuser,  // [1:0] status

    input  logic                        cfg_we,
    input  logic [psb_pkg::SIZE_W-1:0]  cfg_wdata       // sieve_size
);

    import psb_pkg::*;

    // Map address width, and a counter width that holds the size itself and
    // any index or multiple up to twice the depth.
    localparam int unsigned AW = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
    localparam int unsigned SW = (AW + 2 > SIZE_W) ? AW + 2 : SIZE_W;

    localparam logic [SW-1:0] DEPTH_SW = SW'(MAP_DEPTH);
    localparam logic [SW-1:0] TWO_SW   = SW'(2);
    localparam logic [SW-1:0] ONE_SW   = SW'(1);

    // ------------------------------------------------------------------
    // Control and datapath registers
    // ------------------------------------------------------------------
    state_t          state_reg,     state_next;
    logic [SW-1:0]   idx_reg,       idx_next;      // fill index / sieve base
    logic [SW-1:0]   mul_reg,       mul_next;      // multiple being cleared
    logic [SW-1:0]   eff_size_reg;                 // size saturated to depth
    logic            map_ready_reg;

    // Query stage: waits for the memory read data.
    logic            q_valid_reg;
    logic            q_read_reg;                   // result takes the map bit
    status_t         q_status_reg;

    // Output register.
    logic            out_valid_reg;
    logic            out_prime_reg;
    status_t         out_status_reg;

    // Memory port.
    logic            mem_we;
    logic            mem_re;
    logic [AW-1:0]   mem_addr;
    logic            mem_wdata;
    logic            rdata_reg;

    logic            build_done;
    logic            in_xfer;
    logic            q_move;
    logic [SW-1:0]   fill_end;
    logic [SW-1:0]   query_num;
    logic [SW-1:0]   cfg_size;
    logic [SW-1:0]   idx_dbl;
    logic [SW-1:0]   mul_step;
    status_t         query_status;

    // The prime map: one bit per number, read data registered.
    logic            map_mem [MAP_DEPTH];

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            map_mem[mem_addr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= map_mem[mem_addr];
        end
    end

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    // The query stage moves on whenever the output register is empty or is
    // being emptied in this cycle. A new transfer is taken whenever the
    // query stage is free after this edge and no build is running.
    assign q_move        = q_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = (state_reg == ST_IDLE) && (!q_valid_reg || q_move);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, out_prime_reg};
    assign m_axis_tuser  = out_status_reg;

    assign query_num = SW'(s_axis_tdata);
    assign cfg_size  = SW'(cfg_wdata);

    // Not built outranks out of range.
    always_comb
    begin
        priority if (!map_ready_reg)
        begin
            query_status = STATUS_NOT_BUILT;
        end
        else if (query_num >= eff_size_reg)
        begin
            query_status = STATUS_RANGE;
        end
        else
        begin
            query_status = STATUS_OK;
        end
    end

    // The fill always covers entries 0 and 1, even for a size below two.
    assign fill_end = (eff_size_reg < TWO_SW) ? TWO_SW : eff_size_reg;
    assign idx_dbl  = idx_reg + idx_reg;
    assign mul_step = mul_reg + idx_reg;

    // ------------------------------------------------------------------
    // Sequencer: next state and memory port
    // ------------------------------------------------------------------
    // Only one memory access happens per cycle, and a sieve base is read only
    // after all clears of the previous base are written, so reads and writes
    // of the same entry never overlap.
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        mul_next   = mul_reg;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_addr   = query_num[AW-1:0];
        mem_wdata  = 1'b0;
        build_done = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    if (s_axis_tuser[0] == CMD_QUERY)
                    begin
                        mem_re = 1'b1;
                    end
                    else
                    begin
                        idx_next   = '0;
                        state_next = ST_DRAIN;
                    end
                end
            end

            // Let a pending query take its read data before the build
            // starts to use the memory port.
            ST_DRAIN:
            begin
                if (!q_valid_reg)
                begin
                    state_next = ST_FILL;
                end
            end

            ST_FILL:
            begin
                mem_we    = 1'b1;
                mem_addr  = idx_reg[AW-1:0];
                mem_wdata = (idx_reg >= TWO_SW);
                idx_next  = idx_reg + ONE_SW;
                if (idx_reg + ONE_SW >= fill_end)
                begin
                    idx_next   = TWO_SW;
                    state_next = ST_SCAN_RD;
                end
            end

            ST_SCAN_RD:
            begin
                if (idx_reg >= eff_size_reg)
                begin
                    build_done = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_addr   = idx_reg[AW-1:0];
                    state_next = ST_SCAN_CHK;
                end
            end

            ST_SCAN_CHK:
            begin
                if (rdata_reg && (idx_dbl < eff_size_reg))
                begin
                    mul_next   = idx_dbl;
                    state_next = ST_CLEAR;
                end
                else
                begin
                    idx_next   = idx_reg + ONE_SW;
                    state_next = ST_SCAN_RD;
                end
            end

            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_addr  = mul_reg[AW-1:0];
                mem_wdata = 1'b0;
                mul_next  = mul_step;
                if (mul_step >= eff_size_reg)
                begin
                    idx_next   = idx_reg + ONE_SW;
                    state_next = ST_SCAN_RD;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        mul_reg <= mul_next;
    end

    // ------------------------------------------------------------------
    // Configuration and built flag
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eff_size_reg  <= (SW'(SIZE_RESET) > DEPTH_SW) ? DEPTH_SW : SW'(SIZE_RESET);
            map_ready_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            eff_size_reg  <= (cfg_size > DEPTH_SW) ? DEPTH_SW : cfg_size;
            map_ready_reg <= 1'b0;
        end
        else if (build_done)
        begin
            map_ready_reg <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Query stage and output register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_xfer && (s_axis_tuser[0] == CMD_QUERY))
            begin
                q_valid_reg <= 1'b1;
            end
            else if (build_done)
            begin
                q_valid_reg <= 1'b1;
            end
            else if (q_move)
            begin
                q_valid_reg <= 1'b0;
            end

            if (q_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer && (s_axis_tuser[0] == CMD_QUERY))
        begin
            q_read_reg   <= (query_status == STATUS_OK);
            q_status_reg <= query_status;
        end
        else if (build_done)
        begin
            q_read_reg   <= 1'b0;
            q_status_reg <= STATUS_OK;
        end

        if (q_move)
        begin
            out_prime_reg  <= q_read_reg & rdata_reg;
            out_status_reg <= q_status_reg;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_no_write_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !mem_we)
        else $error("map written outside a build");

    a_build_result_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        build_done |-> !q_valid_reg)
        else $error("build finished while a query result was pending");

    a_ready_from_scan: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(map_ready_reg) |-> $past(state_reg == ST_SCAN_RD))
        else $error("map marked built outside the end of a scan");

    a_query_stage_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (q_valid_reg && !out_valid_reg) |=> out_valid_reg)
        else $error("query result did not reach the output register");

    a_build_port_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FILL || state_reg == ST_CLEAR) |-> !mem_re)
        else $error("memory read during a map write phase");

endmodule

[tb/prime_sieve_bitmap_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prime_sieve_bitmap_unit_tb: self-checking bench for the prime sieve unit
// Sends build and query commands over the input stream and changes the sieve
// size between phases. A scoreboard keeps its own copy of the primality map,
// predicts each answer, and compares every returned transfer field by field.
// ----------------------------------------------------------------------------
module prime_sieve_bitmap_unit_tb;

    import psb_pkg::*;

    localparam int unsigned MAP_DEPTH     = MAP_DEPTH_DEFAULT;
    localparam int unsigned TOTAL_ITEMS   = 1100;
    localparam int unsigned CALM_FROM     = 950;
    localparam int unsigned HOLD_CYCLES   = 60;
    localparam int unsigned BURST_ITEMS   = 24;
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned TAIL_CYCLES   = 20;
    // A full-depth build runs with no transfer on either side, so the stall
    // limit has to sit well above the length of that build.
    localparam int unsigned STALL_LIMIT   = 2_000_000;

    // One predicted answer: the is_prime bit and the status code.
    typedef struct packed {
        logic    is_prime;
        status_t status;
    } answer_t;

    // ------------------------------------------------------------------------
    // Scoreboard: mirrors the sieve size, the built flag and the map itself.
    // ------------------------------------------------------------------------
    class sieve_scoreboard;
        bit                prime_bits [MAP_DEPTH];
        bit                map_built;
        logic [SIZE_W-1:0] size_reg;
        answer_t           expected_answers [$];
        int unsigned       error_count;

        function new();
            map_built   = 1'b0;
            size_reg    = SIZE_RESET;
            error_count = 0;
        endfunction

        // Sizes above the map depth saturate to the depth.
        function int unsigned covered_count();
            return (size_reg > MAP_DEPTH) ? MAP_DEPTH : int'(size_reg);
        endfunction

        function void write_size(logic [SIZE_W-1:0] value);
            size_reg  = value;
            map_built = 1'b0;
        endfunction

        function void run_sieve();
            int unsigned n;
            int unsigned i;
            int unsigned j;
            n = covered_count();
            prime_bits[0] = 1'b0;
            prime_bits[1] = 1'b0;
            for (i = 2; i < n; i++)
                prime_bits[i] = 1'b1;
            for (i = 2; i < n; i++)
            begin
                if (prime_bits[i])
                begin
                    for (j = 2 * i; j < n; j += i)
                        prime_bits[j] = 1'b0;
                end
            end
            map_built = 1'b1;
        endfunction

        // Called for every accepted input transfer. A missing map outranks
        // an out-of-range number.
        function void note_item(cmd_t cmd, logic [NUMBER_W-1:0] number);
            answer_t ans;
            ans.is_prime = 1'b0;
            ans.status   = STATUS_OK;
            if (cmd == CMD_BUILD)
                run_sieve();
            else if (!map_built)
                ans.status = STATUS_NOT_BUILT;
            else if (number >= covered_count())
                ans.status = STATUS_RANGE;
            else
                ans.is_prime = prime_bits[number];
            expected_answers.push_back(ans);
        endfunction

        function void check_result(logic [7:0] data, logic [STATUS_W-1:0] user);
            answer_t ans;
            if (expected_answers.size() == 0)
            begin
                $error("result with nothing outstanding: is_prime %b status %0d",
                       data[0], user);
                error_count++;
                return;
            end
            ans = expected_answers.pop_front();
            if (data[0] !== ans.is_prime)
            begin
                $error("is_prime: expected %b, got %b", ans.is_prime, data[0]);
                error_count++;
            end
            if (user !== ans.status)
            begin
                $error("status: expected %0d, got %0d", ans.status, user);
                error_count++;
            end
            if (data[7:1] !== 7'd0)
            begin
                $error("tdata padding: expected 0, got %0h", data[7:1]);
                error_count++;
            end
        endfunction

        function int unsigned pending();
            return expected_answers.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, stimulus signals and the block itself.
    // ------------------------------------------------------------------------
    logic                clk = 1'b0;
    logic                rst_n;

    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [NUMBER_W-1:0] s_axis_tdata;   // [15:0] query_number
    logic [0:0]          s_axis_tuser;   // [0] command

    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [7:0]          m_axis_tdata;   // [0] is_prime, [7:1] zero
    logic [STATUS_W-1:0] m_axis_tuser;   // [1:0] status

    logic                cfg_we;
    logic [SIZE_W-1:0]   cfg_wdata;      // sieve_size

    sieve_scoreboard     board = new();
    int unsigned         items_sent = 0;
    int unsigned         idle_cycles = 0;
    // Set to stop random idling on both sides.
    bit                  calm = 1'b0;
    // Raised by the sender to ask the result side for one long hold-off.
    bit                  hold_results = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    prime_sieve_bitmap_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    // ------------------------------------------------------------------------
    // Driving tasks. Each one is entered just after a rising edge and drives
    // with nonblocking assignments, so the block sees stable inputs.
    // ------------------------------------------------------------------------

    // Offers one item and returns once the transfer has happened. The valid
    // stays high on return, unless a random idle gap drops it, so the next item can follow without a bubble.
    task automatic send_item(input cmd_t cmd, input logic [NUMBER_W-1:0] number);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= number;
        @(posedge clk);
        while (s_axis_tready !== 1'b1)
            @(posedge clk);
        board.note_item(cmd, number);
        items_sent++;
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    endtask

    task automatic query(input logic [NUMBER_W-1:0] number);
        send_item(CMD_QUERY, number);
    endtask

    task automatic build_map();
        send_item(CMD_BUILD, NUMBER_W'($urandom));
    endtask

    // Stops offering input until every predicted answer has come back.
    task automatic wait_results_drained();
        s_axis_tvalid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // The size register is only written while the block is idle.
    task automatic set_sieve_size(input logic [SIZE_W-1:0] value);
        wait_results_drained();
        cfg_wdata <= value;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we    <= 1'b0;
        board.write_size(value);
    endtask

    // Mostly small sizes keep builds short; a few reach the thousands.
    function automatic logic [SIZE_W-1:0] pick_size();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return SIZE_W'($urandom_range(0, 3));
        else if (r < 75)
            return SIZE_W'($urandom_range(4, 256));
        else if (r < 95)
            return SIZE_W'($urandom_range(257, 1024));
        else
            return SIZE_W'($urandom_range(1025, 4096));
    endfunction

    // Most numbers fall inside the map, some straddle its edge, and the rest
    // cover the whole 16-bit range.
    function automatic logic [NUMBER_W-1:0] pick_number(input int unsigned n);
        int unsigned r;
        int          near;
        r = $urandom_range(0, 99);
        if (r < 75 && n > 0)
            return NUMBER_W'($urandom_range(0, n - 1));
        if (r < 90)
        begin
            near = int'(n) + int'($urandom_range(0, 4)) - 2;
            if (near < 0)
                near = 0;
            if (near > 65535)
                near = 65535;
            return NUMBER_W'(near);
        end
        return NUMBER_W'($urandom);
    endfunction

    // ------------------------------------------------------------------------
    // Result side: random stall bursts, one long hold-off on request, and no
    // stalls at all once the run turns calm.
    // ------------------------------------------------------------------------
    initial
    begin : result_sink
        m_axis_tready <= 1'b0;
        @(posedge clk);
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            if (hold_results)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_results = 1'b0;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
            else
            begin
                m_axis_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // Every result transfer is checked against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1)
            board.check_result(m_axis_tdata, m_axis_tuser);
    end

    // The watchdog counts cycles without any transfer on either stream.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid === 1'b1 && s_axis_tready === 1'b1) ||
            (m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        logic [SIZE_W-1:0] size_now;
        int unsigned       phase;
        int unsigned       phase_items;
        int unsigned       k;

        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= CMD_BUILD;
        cfg_we        <= 1'b0;
        cfg_wdata     <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Straight out of reset nothing has been built, so even numbers that
        // lie inside the default size are refused.
        query(16'd0);
        query(16'hFFFF);

        // A size of zero: the missing map outranks the range error, and after
        // a build neither 0 nor 1 lies inside the map.
        set_sieve_size(17'd0);
        query(16'd7);
        build_map();
        query(16'd0);
        query(16'd1);

        // A size of one covers only 0, which is never prime.
        set_sieve_size(17'd1);
        build_map();
        query(16'd0);
        query(16'd1);

        // A size of two still has no primes in it.
        set_sieve_size(17'd2);
        build_map();
        query(16'd0);
        query(16'd1);
        query(16'd2);

        // Rewriting the size drops the built map. All ones in the register
        // saturate to the full depth, which is the one large build of the run.
        set_sieve_size(17'h1FFFF);
        query(16'd1);
        build_map();
        query(16'd2);
        query(16'd3);
        query(16'd4);
        query(16'd65521);
        query(16'd65535);
        query(16'd32749);

        // Back to the reset size: unbuilt again.
        set_sieve_size(SIZE_RESET);
        query(16'd100);

        // Random phases, each with a fresh size and mostly build-then-query
        // traffic.
        phase = 0;
        while (items_sent < TOTAL_ITEMS)
        begin
            size_now = pick_size();
            set_sieve_size(size_now);
            phase_items = $urandom_range(30, 80);

            if (phase == 0)
            begin
                // Wait for the build to finish, then hold the result side
                // off while queries arrive back to back, so the block fills
                // and has to stall its input.
                build_map();
                wait_results_drained();
                hold_results = 1'b1;
                calm = 1'b1;
                for (k = 0; k < BURST_ITEMS; k++)
                    query(pick_number(size_now));
                calm = 1'b0;
            end
            else if ($urandom_range(0, 99) < 85)
            begin
                build_map();
            end

            for (k = 0; k < phase_items && items_sent < TOTAL_ITEMS; k++)
            begin
                if (items_sent >= CALM_FROM)
                    calm = 1'b1;
                if ($urandom_range(0, 99) < 4)
                    build_map();
                else
                    query(pick_number(size_now));
            end
            phase++;
        end

        wait_results_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (board.error_count == 0 && board.pending() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/psb_pkg.sv
hw/rtl/prime_sieve_bitmap_unit.sv
tb/prime_sieve_bitmap_unit_tb.sv
